// ===== rtl/itp_pkg.sv =====
// Shared types, constants and character classification for the infix to
// postfix converter. No dependencies; imported by every module of the block but itp_ram.
package itp_pkg;

  // Default number of entries on the operator stack
  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned SYM_W = 8;

  // Characters with a role of their own
  localparam logic [SYM_W-1:0] CH_POW   = 8'h5E; // '^'
  localparam logic [SYM_W-1:0] CH_MUL   = 8'h2A; // '*'
  localparam logic [SYM_W-1:0] CH_DIV   = 8'h2F; // '/'
  localparam logic [SYM_W-1:0] CH_ADD   = 8'h2B; // '+'
  localparam logic [SYM_W-1:0] CH_SUB   = 8'h2D; // '-'
  localparam logic [SYM_W-1:0] CH_OPEN  = 8'h28; // '('
  localparam logic [SYM_W-1:0] CH_CLOSE = 8'h29; // ')'
  localparam logic [SYM_W-1:0] CH_NONE  = 8'h00; // payload of the end marker

  // One word towards the output stage
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             sym_valid;
    logic             last;
    logic             ovf;
  } emit_t;

  // Operator binding strength: 3 power, 2 multiply/divide, 1 add/subtract
  function automatic logic [1:0] prec(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    case (c)
      CH_POW:         p = 2'd3;
      CH_MUL, CH_DIV: p = 2'd2;
      CH_ADD, CH_SUB: p = 2'd1;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  // ASCII letter, either case
  function automatic logic is_letter(input logic [SYM_W-1:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter: sequencer, stack RAM and
// output register. Depends on itp_pkg, itp_ram, itp_seq and itp_outbuf.
//
// Takes one ASCII character per input word and returns the postfix form as a
// stream of words, closed by a marker word (tlast high, symbol_valid low)
// once the character flagged with tlast has been handled and the stack
// flushed. Letters go straight through; brackets and the operators ^ * / + -
// follow the shunting-yard rules, all left-associative, and any other
// character is an operator of lowest precedence. The operator stack lives in
// a synchronous RAM of STACK_DEPTH entries; a push onto a full stack is
// dropped and sets the overflow bit (tuser[1]) until the marker has gone out.
// Per character: a letter or '(' is handled when it is taken, while ')' or an
// operator goes through the loop that examines the top, where every symbol
// popped waits for the registered stack RAM read (the walk ends early on an
// empty stack); the last character then flushes the stack the same way and
// sends the marker. A new character is only taken while the output register can
// accept a word; after that, output back-pressure stalls the sequencer only
// when a word has to be emitted.
module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [SYM_W-1:0] s_axis_tdata,  // symbol
  input  logic             s_axis_tlast,  // end_of_expr
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [SYM_W-1:0] m_axis_tdata,  // out_symbol
  output logic [1:0]       m_axis_tuser,  // [0] symbol_valid, [1] overflow
  output logic             m_axis_tlast   // last
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic             emit_valid;
  emit_t            emit;
  logic             emit_ready;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [SYM_W-1:0] wr_data;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [SYM_W-1:0] rd_data;

  itp_seq #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .emit_valid_o (emit_valid),
    .emit_o       (emit),
    .emit_ready_i (emit_ready),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data)
  );

  itp_ram #(
    .Width(SYM_W),
    .Depth(STACK_DEPTH)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  itp_outbuf u_outbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_valid_i (emit_valid),
    .emit_i       (emit),
    .emit_ready_o (emit_ready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ===== rtl/itp_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; holds the operator stack.
module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port: hold the last word until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/itp_outbuf.sv =====
// Output register between the sequencer and the master-side stream.
// Depends on itp_pkg for the emit_t word.
module itp_outbuf
  import itp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             emit_valid_i,
  input  emit_t            emit_i,
  output logic             emit_ready_o,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [SYM_W-1:0] m_axis_tdata,  // out_symbol
  output logic [1:0]       m_axis_tuser,  // [0] symbol_valid, [1] overflow
  output logic             m_axis_tlast   // last
);

  logic  valid_q;
  emit_t word_q;

  assign emit_ready_o = !valid_q || m_axis_tready;

  // Hold a word until the sink takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit_ready_o) begin
      valid_q <= emit_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_ready_o && emit_valid_i) begin
      word_q <= emit_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = word_q.sym;
  assign m_axis_tuser  = {word_q.ovf, word_q.sym_valid};
  assign m_axis_tlast  = word_q.last;

endmodule

// ===== rtl/itp_seq.sv =====
// Shunting-yard sequencer: classifies each character and walks the operator
// stack held in RAM. Depends on itp_pkg and drives one itp_ram instance.
module itp_seq
  import itp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [SYM_W-1:0]               s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           emit_valid_o,
  output emit_t                          emit_o,
  input  logic                           emit_ready_i,
  output logic                           wr_en_o,
  output logic [$clog2(STACK_DEPTH)-1:0] wr_addr_o,
  output logic [SYM_W-1:0]               wr_data_o,
  output logic                           rd_en_o,
  output logic [$clog2(STACK_DEPTH)-1:0] rd_addr_o,
  input  logic [SYM_W-1:0]               rd_data_i
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_TOP, ST_EVAL, ST_END} state_e;
  typedef enum logic [1:0] {MD_CLOSE, MD_OPER, MD_FLUSH} mode_e;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             end_q, end_d;
  logic [CW-1:0]    count_q, count_d;
  logic             ovf_q, ovf_d;

  logic [CW-1:0]    count_m1;
  logic             push;
  logic [SYM_W-1:0] push_sym;
  logic             pop_top;

  assign count_m1  = count_q - 1'b1;
  assign rd_addr_o = count_m1[AW-1:0];
  assign wr_addr_o = count_q[AW-1:0];
  assign wr_data_o = push_sym;
  assign wr_en_o   = push && (count_q != FULL);

  // Decide whether the symbol read from the top leaves the stack
  always_comb begin
    case (mode_q)
      MD_FLUSH: pop_top = 1'b1;
      MD_CLOSE: pop_top = (rd_data_i != CH_OPEN);
      MD_OPER:  pop_top = (prec(sym_q) <= prec(rd_data_i));
      default:  pop_top = 1'b0;
    endcase
  end

  // Next state, stack traffic and output words
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    sym_d         = sym_q;
    end_d         = end_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    push          = 1'b0;
    push_sym      = sym_q;
    rd_en_o       = 1'b0;
    s_axis_tready = 1'b0;
    emit_valid_o  = 1'b0;
    emit_o        = '{sym: rd_data_i, sym_valid: 1'b1, last: 1'b0, ovf: ovf_q};

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = emit_ready_i;
        if (s_axis_tvalid && emit_ready_i) begin
          sym_d   = s_axis_tdata;
          end_d   = s_axis_tlast;
          mode_d  = MD_OPER;
          state_d = ST_END;
          if (is_letter(s_axis_tdata)) begin
            emit_valid_o = 1'b1;
            emit_o.sym   = s_axis_tdata;
          end else if (s_axis_tdata == CH_OPEN) begin
            push     = 1'b1;
            push_sym = s_axis_tdata;
          end else if (s_axis_tdata == CH_CLOSE) begin
            mode_d  = MD_CLOSE;
            state_d = ST_TOP;
          end else begin
            state_d = ST_TOP;
          end
        end
      end
      ST_TOP: begin
        if (count_q == '0) begin
          push    = (mode_q == MD_OPER);
          state_d = ST_END;
        end else begin
          rd_en_o = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (pop_top) begin
          emit_valid_o = 1'b1;
          if (emit_ready_i) begin
            count_d = count_m1;
            state_d = ST_TOP;
          end
        end else if (mode_q == MD_CLOSE) begin
          // drop the matching open bracket
          count_d = count_m1;
          state_d = ST_END;
        end else begin
          push    = 1'b1;
          state_d = ST_END;
        end
      end
      ST_END: begin
        if (!end_q) begin
          state_d = ST_IDLE;
        end else if (mode_q != MD_FLUSH) begin
          mode_d  = MD_FLUSH;
          state_d = ST_TOP;
        end else begin
          emit_valid_o = 1'b1;
          emit_o       = '{sym: CH_NONE, sym_valid: 1'b0, last: 1'b1, ovf: ovf_q};
          if (emit_ready_i) begin
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // Push, or flag a dropped push on a full stack
    if (push) begin
      if (count_q == FULL) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MD_OPER;
      end_q   <= 1'b0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      sym_q   <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      end_q   <= end_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      sym_q   <= sym_d;
    end
  end

  // The stack never holds more entries than it has
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL) else $error("stack count beyond depth");

  // The end marker only goes out once the stack is empty
  a_marker_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_valid_o && emit_o.last) |-> (count_q == '0))
    else $error("end marker with symbols left on the stack");

  // A popped word takes exactly one entry off the stack
  a_pop_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && emit_valid_o && emit_ready_i)
      |=> (count_q == $past(count_m1)))
    else $error("pop did not shrink the stack by one");

  // A stack read never shares a cycle with a stack write
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_o |-> !wr_en_o) else $error("stack read and write in one cycle");

endmodule
